// ----- hw/rtl/aging_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Aging priority queue assertion macros
// Shared property forms for the queue's internal checks.
// ----------------------------------------------------------------------------
`ifndef AGING_PRIORITY_QUEUE_DEFINES_SVH
`define AGING_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define APQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define APQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// Aging priority queue package
// Widths, operation codes and shared types of the queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int PRI_W     = 8;
  localparam int OCC_W     = 6;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_AGE   = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } apq_entry_t;

  typedef struct packed {
    logic             shift;
    logic [PRI_W-1:0] aged;
  } apq_alu_res_t;

endpackage

// ----- hw/rtl/apq_alu.sv -----
// ----------------------------------------------------------------------------
// Aging priority queue compare unit
// Shared compare and saturating decrement on one stored priority.
// ----------------------------------------------------------------------------
module apq_alu (
  input  logic [apq_pkg::PRI_W-1:0] stored_pri,
  input  logic [apq_pkg::PRI_W-1:0] req_pri,
  output apq_pkg::apq_alu_res_t     res
);

  localparam logic [apq_pkg::PRI_W-1:0] PRI_ONE = 1;

  always_comb begin
    res.shift = (stored_pri <= req_pri);
    res.aged  = (stored_pri == '0) ? '0 : (stored_pri - PRI_ONE);
  end

endmodule

// ----- hw/rtl/aging_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Aging priority queue
// Sorted queue of id and priority entries with enqueue, dequeue, age, flush.
// ----------------------------------------------------------------------------
// One operation at a time, each giving one result transfer. Entries sit in a
// single memory with one write and one registered read port, swept by a small
// sequencer through one shared compare unit. Flush, or any operation that finds
// nothing to do, goes straight to the result stage; dequeue reads the tail
// entry; age rewrites every stored entry in turn; enqueue walks down from the
// tail, moving up one slot each stored entry whose priority number is not above
// the new one, then writes the new entry. The memory port reads one entry and
// writes one per cycle. in_stall is high from the accepted transfer until the
// result has been loaded into the output register.
`include "aging_priority_queue_defines.svh"

module aging_priority_queue #(
  parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [apq_pkg::OP_W-1:0]  in_op,
  input  logic [apq_pkg::ID_W-1:0]  in_item_id,
  input  logic [apq_pkg::PRI_W-1:0] in_priority_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [apq_pkg::ID_W-1:0]  out_served_id,
  output logic                      out_served_valid,
  output logic                      out_dropped,
  output logic [apq_pkg::OCC_W-1:0] out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_DEQ  = 3'd2;
  localparam logic [2:0] ST_AGE  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [AW-1:0]               k_r, k_nxt;
  apq_pkg::apq_entry_t         req_r, req_nxt;
  logic [apq_pkg::ID_W-1:0]    res_id_r, res_id_nxt;
  logic                        res_valid_r, res_valid_nxt;
  logic                        res_drop_r, res_drop_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [apq_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic                        out_sv_r, out_sv_nxt;
  logic                        out_drop_r, out_drop_nxt;
  logic [apq_pkg::OCC_W-1:0]   out_occ_r, out_occ_nxt;

  apq_pkg::apq_entry_t         mem [DEPTH];
  apq_pkg::apq_entry_t         rd_q;
  apq_pkg::apq_entry_t         wr_data;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;

  logic [CW-1:0]               count_m1;
  logic [AW-1:0]               pos_m1;
  apq_pkg::apq_alu_res_t       alu;

  apq_alu u_alu (
    .stored_pri (rd_q.pri),
    .req_pri    (req_r.pri),
    .res        (alu)
  );

  assign count_m1 = count_r - CW'(1);
  assign pos_m1   = pos_r - AW'(1);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    req_nxt       = req_r;
    res_id_nxt    = res_id_r;
    res_valid_nxt = res_valid_r;
    res_drop_nxt  = res_drop_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_id_nxt    = out_id_r;
    out_sv_nxt    = out_sv_r;
    out_drop_nxt  = out_drop_r;
    out_occ_nxt   = out_occ_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_q;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt       = '{id: in_item_id, pri: in_priority_req};
          res_id_nxt    = '0;
          res_valid_nxt = 1'b0;
          res_drop_nxt  = 1'b0;
          unique case (in_op)
            apq_pkg::OP_ENQ: begin
              if (count_r == CW'(DEPTH)) begin
                res_drop_nxt = 1'b1;
                state_nxt    = ST_FIN;
              end else begin
                pos_nxt   = count_r[AW-1:0];
                rd_en     = (count_r != '0);
                rd_addr   = count_m1[AW-1:0];
                state_nxt = ST_INS;
              end
            end
            apq_pkg::OP_DEQ: begin
              if (count_r == '0) begin
                state_nxt = ST_FIN;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = count_m1[AW-1:0];
                count_nxt = count_m1;
                state_nxt = ST_DEQ;
              end
            end
            apq_pkg::OP_AGE: begin
              if (count_r == '0) begin
                state_nxt = ST_FIN;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                k_nxt     = '0;
                state_nxt = ST_AGE;
              end
            end
            apq_pkg::OP_FLUSH: begin
              count_nxt = '0;
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if ((pos_r != '0) && alu.shift) begin
          wr_data = rd_q;
          pos_nxt = pos_m1;
          if (pos_m1 != '0) begin
            rd_en   = 1'b1;
            rd_addr = pos_m1 - AW'(1);
          end
        end else begin
          wr_data   = req_r;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_FIN;
        end
      end
      ST_DEQ: begin
        res_id_nxt    = rd_q.id;
        res_valid_nxt = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_AGE: begin
        wr_en   = 1'b1;
        wr_addr = k_r;
        wr_data = '{id: rd_q.id, pri: alu.aged};
        if (k_r == count_m1[AW-1:0]) begin
          state_nxt = ST_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k_r + AW'(1);
          k_nxt   = k_r + AW'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_sv_nxt    = res_valid_r;
          out_drop_nxt  = res_drop_r;
          out_occ_nxt   = apq_pkg::OCC_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    req_r       <= req_nxt;
    res_id_r    <= res_id_nxt;
    res_valid_r <= res_valid_nxt;
    res_drop_r  <= res_drop_nxt;
    out_id_r    <= out_id_nxt;
    out_sv_r    <= out_sv_nxt;
    out_drop_r  <= out_drop_nxt;
    out_occ_r   <= out_occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_served_id    = out_id_r;
  assign out_served_valid = out_sv_r;
  assign out_dropped      = out_drop_r;
  assign out_occupancy    = out_occ_r;

  `APQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `APQ_ASSERT_IMP(a_ins_pos, state_r == ST_INS, CW'(pos_r) <= count_r, "insert slot beyond fill")
  `APQ_ASSERT_IMP(a_age_idx, state_r == ST_AGE, CW'(k_r) < count_r, "age index beyond fill")
  `APQ_ASSERT_NXT(a_busy, in_valid && !in_stall, state_r != ST_IDLE, "idle after transfer")
  `APQ_ASSERT_IMP(a_serve_drop, out_valid_r && out_sv_r, !out_drop_r, "served and dropped")

endmodule

// ----- tb/aging_priority_queue_checker.sv -----
// ----------------------------------------------------------------------------
// Aging priority queue result checker
// Watches both channels of the queue. Every accepted input transfer is run
// through a local model of the sorted store, and the predicted result is
// queued. Every accepted result transfer is compared field by field against
// the oldest prediction. Mismatch and pending counts go back to the bench.
// ----------------------------------------------------------------------------
module aging_priority_queue_checker
  import apq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [OP_W-1:0]  in_op,
  input  logic [ID_W-1:0]  in_item_id,
  input  logic [PRI_W-1:0] in_priority_req,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [ID_W-1:0]  out_served_id,
  input  logic             out_served_valid,
  input  logic             out_dropped,
  input  logic [OCC_W-1:0] out_occupancy,
  output int               mismatches,
  output int               pending,
  output int               served_seen,
  output int               dropped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]  served_id;
    logic             served_valid;
    logic             dropped;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  logic [ID_W-1:0]  slot_id  [DEPTH];
  logic [PRI_W-1:0] slot_pri [DEPTH];
  int               held;

  queue_result_t awaited_results[$];
  int            mismatch_total;
  int            served_total;
  int            dropped_total;

  function automatic queue_result_t predict_queue_op(input logic [OP_W-1:0] op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [PRI_W-1:0] pri);
    queue_result_t r;
    int pos;
    r = '0;
    case (op)
      OP_ENQ: begin
        if (held >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          pos = held;
          while (pos > 0 && slot_pri[pos-1] <= pri) begin
            slot_id[pos]  = slot_id[pos-1];
            slot_pri[pos] = slot_pri[pos-1];
            pos--;
          end
          slot_id[pos]  = id;
          slot_pri[pos] = pri;
          held++;
        end
      end
      OP_DEQ: begin
        if (held > 0) begin
          held--;
          r.served_id    = slot_id[held];
          r.served_valid = 1'b1;
        end
      end
      OP_AGE: begin
        for (int k = 0; k < held; k++) begin
          if (slot_pri[k] != '0) begin
            slot_pri[k] = slot_pri[k] - 1'b1;
          end
        end
      end
      default: begin
        held = 0;
      end
    endcase
    r.occupancy = held[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    queue_result_t seen;
    queue_result_t want;
    if (!rst_n) begin
      held = 0;
      awaited_results.delete();
      mismatch_total = 0;
      served_total   = 0;
      dropped_total  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_served_id, out_served_valid, out_dropped, out_occupancy};
        if (seen.served_valid) served_total++;
        if (seen.dropped) dropped_total++;
        if (awaited_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: result transfer with nothing outstanding:", $realtime);
            $display("  id %0d valid %0b drop %0b occ %0d",
                     seen.served_id, seen.served_valid, seen.dropped,
                     seen.occupancy);
          end
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: result mismatch:", $realtime);
              $display("  expected id %0d valid %0b drop %0b occ %0d",
                       want.served_id, want.served_valid, want.dropped,
                       want.occupancy);
              $display("  got      id %0d valid %0b drop %0b occ %0d",
                       seen.served_id, seen.served_valid, seen.dropped,
                       seen.occupancy);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_queue_op(in_op, in_item_id, in_priority_req));
      end
    end
    mismatches   <= mismatch_total;
    pending      <= awaited_results.size();
    served_seen  <= served_total;
    dropped_seen <= dropped_total;
  end

endmodule

// ----- tb/tb_aging_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Aging priority queue testbench
// Drives a short directed sequence (empty-queue operations, field extremes,
// equal-priority ordering, ageing at zero, flush) and then random phases that
// fill, drain, age and mix operations, with random idling on both channels.
// Checking is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_aging_priority_queue;
  import apq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 500000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_op = OP_DEQ;
  logic [ID_W-1:0]  in_item_id = '0;
  logic [PRI_W-1:0] in_priority_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ID_W-1:0]  out_served_id;
  logic             out_served_valid;
  logic             out_dropped;
  logic [OCC_W-1:0] out_occupancy;

  int mismatches;
  int pending;
  int served_seen;
  int dropped_seen;
  int cycle_count = 0;
  int op_tally[4] = '{0, 0, 0, 0};
  bit quiet = 1'b0;

  aging_priority_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_item_id       (in_item_id),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_served_id    (out_served_id),
    .out_served_valid (out_served_valid),
    .out_dropped      (out_dropped),
    .out_occupancy    (out_occupancy)
  );

  aging_priority_queue_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_item_id       (in_item_id),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_served_id    (out_served_id),
    .out_served_valid (out_served_valid),
    .out_dropped      (out_dropped),
    .out_occupancy    (out_occupancy),
    .mismatches       (mismatches),
    .pending          (pending),
    .served_seen      (served_seen),
    .dropped_seen     (dropped_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("aging_priority_queue verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_item_id      <= id;
    in_priority_req <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_tally[op]++;
  endtask

  initial begin
    int random_sent;
    int phase;
    int kind;
    int span;
    int roll;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;

    random_sent = 0;
    phase = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue
    send_item(OP_DEQ, 8'hFF, 8'hFF);
    send_item(OP_AGE, 8'h5A, 8'h00);
    send_item(OP_FLUSH, 8'hA5, 8'hFF);
    // extremes and equal priorities
    send_item(OP_ENQ, 8'hFF, 8'hFF);
    send_item(OP_ENQ, 8'h00, 8'h00);
    send_item(OP_ENQ, 8'hA5, 8'h07);
    send_item(OP_ENQ, 8'h5A, 8'h07);
    send_item(OP_ENQ, 8'h3C, 8'h07);
    // age with an entry already at zero
    send_item(OP_AGE, 8'hFF, 8'hFF);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'hFF, 8'hFF);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_ENQ, 8'h11, 8'h00);
    send_item(OP_ENQ, 8'h22, 8'h00);
    send_item(OP_AGE, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'hFF, 8'hFF);
    send_item(OP_ENQ, 8'hFF, 8'h80);
    send_item(OP_ENQ, 8'h01, 8'h7F);
    send_item(OP_FLUSH, 8'h00, 8'h00);
    send_item(OP_DEQ, 8'h00, 8'h00);

    while (random_sent < 1100) begin
      kind  = $urandom_range(3);
      quiet = (phase == 4);
      if (quiet) span = 150;
      else if (kind == 0) span = $urandom_range(70, 45);
      else span = $urandom_range(60, 20);
      for (int k = 0; k < span; k++) begin
        roll = $urandom_range(99);
        case (kind)
          0: begin
            if (roll < 85) op = OP_ENQ;
            else if (roll < 95) op = OP_DEQ;
            else op = OP_AGE;
          end
          1: begin
            if (roll < 75) op = OP_DEQ;
            else if (roll < 95) op = OP_ENQ;
            else op = OP_AGE;
          end
          2: begin
            if (roll < 40) op = OP_ENQ;
            else if (roll < 75) op = OP_DEQ;
            else if (roll < 95) op = OP_AGE;
            else op = OP_FLUSH;
          end
          default: begin
            if (roll < 45) op = OP_ENQ;
            else if (roll < 85) op = OP_AGE;
            else op = OP_DEQ;
          end
        endcase
        id  = ID_W'($urandom_range(255));
        pri = PRI_W'($urandom_range(1) ? $urandom_range(7) : $urandom_range(255));
        send_item(op, id, pri);
        random_sent++;
      end
      phase++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEPTH_DEF + 8) @(posedge clk);

    $display("Ran %0d enqueue, %0d dequeue, %0d age and %0d flush operations",
             op_tally[OP_ENQ], op_tally[OP_DEQ], op_tally[OP_AGE], op_tally[OP_FLUSH]);
    $display("%0d entries served, %0d enqueues refused on a full queue, %0d mismatches",
             served_seen, dropped_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("aging_priority_queue verification clean");
    end else begin
      $display("aging_priority_queue verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/apq_pkg.sv
hw/rtl/apq_alu.sv
hw/rtl/aging_priority_queue.sv
tb/aging_priority_queue_checker.sv
tb/tb_aging_priority_queue.sv
